>>> hdl/sbda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types of the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

   // field widths
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 7;

   // number of decimal digits of the largest magnitude, and the bcd word
   localparam int NUM_DIGITS  = 20;
   localparam int DIGIT_W     = 4;
   localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_W);

   // characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   // operations of the bcd shift register
   typedef logic [1:0] bcd_op_type;
   localparam bcd_op_type BCD_HOLD   = 2'd0;
   localparam bcd_op_type BCD_CLEAR  = 2'd1;
   localparam bcd_op_type BCD_DABBLE = 2'd2;
   localparam bcd_op_type BCD_DIGIT  = 2'd3;

   // control from the sequencer to the bcd shift register
   typedef struct packed {
      bcd_op_type op;
      logic       bit_in;
   } bcd_ctl_type;

endpackage

>>> hdl/sbda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda request and response channels
// Valid/ready channels carrying the input value and the output characters.
// ----------------------------------------------------------------------------
interface sbda_req_if;
   import sbda_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   import sbda_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ascii_char;
   logic              last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

>>> hdl/sbda_bcd_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_bcd_shift
// Double dabble shift register: takes the magnitude one bit per dabble cycle,
// then hands out decimal digits one per digit cycle, most significant first.
// ----------------------------------------------------------------------------
module sbda_bcd_shift (
   input  logic                         clock,
   input  sbda_pkg::bcd_ctl_type        ctl,
   output logic [sbda_pkg::DIGIT_W-1:0] top_digit
);
   import sbda_pkg::*;

   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] bcd_in;
   logic [BCD_W-1:0] adj;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // next value per operation
   always_comb begin
      unique case (ctl.op)
         BCD_CLEAR:  bcd_in = '0;
         BCD_DABBLE: bcd_in = {adj[BCD_W-2:0], ctl.bit_in};
         BCD_DIGIT:  bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         default:    bcd_in = bcd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule

>>> hdl/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Steps: take the value, run the double dabble over all 64 bits, drop leading
// zeros and pick the first character, send a minus sign when negative, then
// send one character beat per cycle while the sink is ready.
// A new value is taken only once the last character of the previous one is
// loaded; the serial double dabble and the digit walk keep the block busy.
// Reset (synchronous, active high) empties the output register and returns
// the sequencer to idle; it needs no clearing pass.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 64-bit value to its decimal text, one ASCII character
// per response beat, minus sign first, with leading zeros suppressed.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   sbda_req_if.sink   req_if,
   sbda_rsp_if.source rsp_if
);
   import sbda_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]             state_ff,  state_in;
   logic [VALUE_W-1:0]     mag_ff,    mag_in;
   logic                   neg_ff,    neg_in;
   logic [BIT_CNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [DIGIT_CNT_W-1:0] dcnt_ff,   dcnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff,  rsp_char_in;
   logic                   rsp_last_ff,  rsp_last_in;

   bcd_ctl_type            bcd_ctl;
   logic [DIGIT_W-1:0]     top_digit;
   logic                   out_free;
   logic                   load;

   sbda_bcd_shift u_bcd (
      .clock     (clock),
      .ctl       (bcd_ctl),
      .top_digit (top_digit)
   );

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      bitcnt_in      = bitcnt_ff;
      dcnt_in        = dcnt_ff;
      bcd_ctl.op     = BCD_HOLD;
      bcd_ctl.bit_in = mag_ff[VALUE_W-1];
      load           = 1'b0;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               neg_in     = req_if.value[VALUE_W-1];
               mag_in     = req_if.value[VALUE_W-1] ? (~req_if.value + 1'b1)
                                                    : req_if.value;
               bitcnt_in  = '0;
               bcd_ctl.op = BCD_CLEAR;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_ctl.op = BCD_DABBLE;
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in  = bitcnt_ff + 1'b1;
            if (bitcnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               dcnt_in  = DIGIT_CNT_W'(NUM_DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && dcnt_ff != DIGIT_CNT_W'(1)) begin
               bcd_ctl.op = BCD_DIGIT;
               dcnt_in    = dcnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
               rsp_last_in = (dcnt_ff == DIGIT_CNT_W'(1));
               bcd_ctl.op  = BCD_DIGIT;
               dcnt_in     = dcnt_ff - 1'b1;
               if (dcnt_ff == DIGIT_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bitcnt_ff   <= bitcnt_in;
      dcnt_ff     <= dcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ascii_char = rsp_char_ff;
   assign rsp_if.last_char  = rsp_last_ff;

endmodule

>>> hdl/sbda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_checker
// Port-level checks of the converter's response channel, bound to the top.
// ----------------------------------------------------------------------------
module sbda_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sbda_pkg::CHAR_W-1:0] rsp_ascii_char,
   input logic                        rsp_last_char
);
   import sbda_pkg::*;

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_ascii_char) && $stable(rsp_last_char))
      else $error("response payload changed while stalled");

   // only a minus sign or a decimal digit is ever sent
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CHAR_MINUS) ||
                    (rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= CHAR_NINE))
      else $error("response character out of range");

   // a minus sign is never the end of a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == CHAR_MINUS |-> !rsp_last_char)
      else $error("minus sign marked as last character");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_ascii_char (rsp_if.ascii_char),
   .rsp_last_char  (rsp_if.last_char)
);
